// ===== design/tse_pkg.sv =====
`default_nettype none
package tse_pkg;

    typedef struct packed {
        logic       command;
        logic [5:0] from_vertex;
        logic [5:0] to_vertex;
    } t_in_item;

    typedef struct packed {
        logic [5:0] vertex_number;
        logic       vertex_valid;
        logic       last;
        logic       has_cycle;
        logic       edge_overflow;
    } t_out_item;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // controller commands to the datapath
    typedef struct packed {
        logic add_edge;
        logic clr_deg;
        logic deg_head;
        logic deg_step;
        logic push_scan;
        logic pop;
        logic dec_step;
        logic emit_last;
        logic clear;
    } t_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic vtx_done;
        logic list_end;
        logic stack_empty;
    } t_status;

endpackage
`default_nettype wire

// ===== design/topological_sort_engine.sv =====
`default_nettype none
// topological sort engine, kahn's method with a lifo ready stack
// input: start with an item while busy is low starts a transaction.
// command 0 stores an edge and gives no result; busy stays low.
// command 1 runs the sort: busy rises the next cycle and stays high
// for the whole run. a run clears the in-degrees, counts them over the stored
// edges, pushes the ready vertices, then pops one vertex at a time and steps
// through its successor edges, until it finds the stack empty; then it makes
// the final transaction.
// the run is set by the walk over the edge lists, one edge per cycle through
// the edge memory, whose read data is registered.
// results: o_strobe marks one result for one cycle; the receiver cannot
// stall. each vertex comes out the cycle after the next pop or the final step.
// the last result carries last, has_cycle and edge_overflow and is on the
// ports in the first cycle with busy low.
// a run that emits nothing gives one result with vertex_valid low.
// the graph is cleared after each run. config: i_cfg_we writes vertex_count;
// the user must do so only while idle; the block does not enforce it.
// reset: synchronous, clears the graph and vertex_count.
module topological_sort_engine
    import tse_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 128
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_in_item i_item,
    input  wire logic     i_cfg_we,
    input  wire logic [5:0] i_cfg_data,
    output logic          o_strobe,
    output t_out_item     o_result
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_busy;

    tse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_command(i_item.command),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (w_busy)
    );

    tse_datapath #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_EDGES   (MAX_EDGES)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_item    (i_item),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .o_valid   (o_strobe),
        .o_result  (o_result)
    );

    assign busy = w_busy;

endmodule
`default_nettype wire

// ===== design/tse_ctrl.sv =====
`default_nettype none
module tse_ctrl
    import tse_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_command,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_busy
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLR   = 8'b0000_0010,
        S_HEAD  = 8'b0000_0100,
        S_DEG   = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_POP   = 8'b0010_0000,
        S_DEC   = 8'b0100_0000,
        S_LAST  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_command == CMD_EDGE) o_cmd.add_edge = 1'b1;
                if (i_start && i_command == CMD_RUN) n_state = S_CLR;
            end
            S_CLR: begin
                o_cmd.clr_deg = 1'b1;
                if (i_status.vtx_done) n_state = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.deg_head = 1'b1;
                if (i_status.vtx_done) n_state = S_SCAN;
                else n_state = S_DEG;
            end
            S_DEG: begin
                o_cmd.deg_step = 1'b1;
                if (i_status.list_end) n_state = S_HEAD;
            end
            S_SCAN: begin
                o_cmd.push_scan = 1'b1;
                if (i_status.vtx_done) n_state = S_POP;
            end
            S_POP: begin
                if (i_status.stack_empty) n_state = S_LAST;
                else begin
                    o_cmd.pop = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.dec_step = 1'b1;
                if (i_status.list_end) n_state = S_POP;
            end
            S_LAST: begin
                o_cmd.emit_last = 1'b1;
                o_cmd.clear = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== design/tse_datapath.sv =====
`default_nettype none
module tse_datapath
    import tse_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 128
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic [5:0] i_cfg_data,
    input  wire t_in_item i_item,
    input  wire t_cmd     i_cmd,
    output t_status       o_status,
    output logic          o_valid,
    output t_out_item     o_result
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int PW = EW + 1;           // edge pointer, 0 = null
    localparam int DW = EW + 1;           // in-degree width
    localparam int CW = VW + 1;           // count width

    logic [5:0] r_vcount;
    logic [CW-1:0] w_n;

    logic [VW-1:0] r_tgt  [MAX_EDGES];
    logic [PW-1:0] r_next [MAX_EDGES];
    logic [PW-1:0] r_head [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_head_ok;
    logic [DW-1:0] r_deg  [MAX_VERTICES];
    logic [VW-1:0] r_stack[MAX_VERTICES];

    logic [PW-1:0] r_total;
    logic          r_ovf;
    logic [CW-1:0] r_sp;
    logic [CW-1:0] r_vi;
    logic [PW-1:0] r_ptr;
    logic [PW-1:0] n_ptr;
    logic [EW-1:0] w_rd_addr;
    logic [VW-1:0] r_rd_tgt;
    logic [PW-1:0] r_rd_next;
    logic [CW-1:0] r_emitted;
    logic [5:0]    r_last_v;
    logic          r_pend;

    // effective vertex count
    always_comb begin
        if ({1'b0, r_vcount} > 7'(MAX_VERTICES)) w_n = CW'(MAX_VERTICES);
        else w_n = CW'(r_vcount);
    end

    // edge acceptance
    logic w_a_ok, w_b_ok, w_full;
    assign w_a_ok = i_item.from_vertex != 6'd0 && {1'b0, i_item.from_vertex} <= 7'(w_n);
    assign w_b_ok = i_item.to_vertex != 6'd0 && {1'b0, i_item.to_vertex} <= 7'(w_n);
    assign w_full = r_total >= PW'(MAX_EDGES);

    logic [VW-1:0] w_a, w_b;
    assign w_a = VW'(i_item.from_vertex - 6'd1);
    assign w_b = VW'(i_item.to_vertex - 6'd1);

    logic [PW-1:0] w_head_a;
    assign w_head_a = r_head_ok[w_a] ? r_head[w_a] : '0;

    // current list walk, edge fields are registered together with the pointer
    logic [VW-1:0] w_t;
    logic          w_t_in;
    logic [PW-1:0] w_nx;
    assign w_t    = r_rd_tgt;
    assign w_nx   = r_rd_next;
    assign w_t_in = CW'(w_t) < w_n;

    logic [VW-1:0] w_vi;
    assign w_vi = VW'(r_vi);
    logic [VW-1:0] w_top;
    assign w_top = r_stack[VW'(r_sp - CW'(1))];

    // next list pointer, also the edge memory read address
    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.deg_head && r_vi < w_n) n_ptr = r_head_ok[w_vi] ? r_head[w_vi] : '0;
        if ((i_cmd.deg_step || i_cmd.dec_step) && r_ptr != '0) n_ptr = w_nx;
        if (i_cmd.pop) n_ptr = r_head_ok[w_top] ? r_head[w_top] : '0;
    end
    assign w_rd_addr = EW'(n_ptr - PW'(1));

    assign o_status.vtx_done    = (r_vi >= w_n);
    assign o_status.list_end    = (r_ptr == '0);
    assign o_status.stack_empty = (r_sp == '0);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vcount <= '0;
        else if (i_cfg_we) r_vcount <= i_cfg_data;
    end

    // edge store memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_edge && i_item.command == CMD_EDGE && w_a_ok && w_b_ok && !w_full) begin
            r_tgt[EW'(r_total)]  <= w_b;
            r_next[EW'(r_total)] <= w_head_a;
            r_head[w_a]          <= r_total + PW'(1);
        end
        r_rd_tgt  <= r_tgt[w_rd_addr];
        r_rd_next <= r_next[w_rd_addr];
    end

    // control and run registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_ok <= '0;
            r_total   <= '0;
            r_ovf     <= 1'b0;
            r_sp      <= '0;
            r_vi      <= '0;
            r_ptr     <= '0;
            r_emitted <= '0;
            r_pend    <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= (i_cmd.pop && r_pend) || i_cmd.emit_last;
            r_ptr   <= n_ptr;
            if (i_cmd.add_edge && i_item.command == CMD_EDGE && w_a_ok && w_b_ok) begin
                if (w_full) r_ovf <= 1'b1;
                else begin
                    r_head_ok[w_a] <= 1'b1;
                    r_total <= r_total + PW'(1);
                end
            end
            // clear in-degrees
            if (i_cmd.clr_deg) begin
                if (r_vi < w_n) begin
                    r_deg[w_vi] <= '0;
                    r_vi <= r_vi + CW'(1);
                end else r_vi <= '0;
            end
            // step through list heads for counting
            if (i_cmd.deg_head) begin
                if (r_vi < w_n) begin
                    r_vi  <= r_vi + CW'(1);
                end else begin
                    r_vi <= '0;
                    r_sp <= '0;
                end
            end
            // count one edge
            if (i_cmd.deg_step && r_ptr != '0) begin
                if (w_t_in) r_deg[w_t] <= r_deg[w_t] + DW'(1);
            end
            // push zero in-degree vertices ascending
            if (i_cmd.push_scan && r_vi < w_n) begin
                if (r_deg[w_vi] == '0) begin
                    r_stack[VW'(r_sp)] <= w_vi;
                    r_sp <= r_sp + CW'(1);
                end
                r_vi <= r_vi + CW'(1);
            end
            // pop and emit previous
            if (i_cmd.pop) begin
                r_sp  <= r_sp - CW'(1);
                if (r_pend) begin
                    o_result <= '{vertex_number: r_last_v, vertex_valid: 1'b1,
                                  last: 1'b0, has_cycle: 1'b0, edge_overflow: 1'b0};
                end
                r_last_v  <= 6'(w_top) + 6'd1;
                r_pend    <= 1'b1;
                r_emitted <= r_emitted + CW'(1);
            end
            // decrement one successor
            if (i_cmd.dec_step && r_ptr != '0) begin
                if (w_t_in && r_deg[w_t] != '0) begin
                    r_deg[w_t] <= r_deg[w_t] - DW'(1);
                    if (r_deg[w_t] == DW'(1) && r_sp < CW'(MAX_VERTICES)) begin
                        r_stack[VW'(r_sp)] <= w_t;
                        r_sp <= r_sp + CW'(1);
                    end
                end
            end
            // final transaction and graph clear
            if (i_cmd.emit_last) begin
                o_result <= '{vertex_number: r_pend ? r_last_v : 6'd0,
                              vertex_valid: r_pend, last: 1'b1,
                              has_cycle: r_emitted < w_n, edge_overflow: r_ovf};
            end
            if (i_cmd.clear) begin
                r_head_ok <= '0;
                r_total   <= '0;
                r_ovf     <= 1'b0;
                r_sp      <= '0;
                r_vi      <= '0;
                r_emitted <= '0;
                r_pend    <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire
